>>> rtl/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// Field widths and operation codes shared by the handle slot registry files.
// ----------------------------------------------------------------------------
`default_nettype none

package hsr_pkg;

  localparam int MODE_W     = 3;
  localparam int HANDLE_W   = 32;
  localparam int START_W    = 9;
  localparam int SLOT_OUT_W = 8;
  localparam int OCC_W      = 9;

  localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PREV       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_COUNT      = 3'd5;
  localparam logic [MODE_W-1:0] MODE_INVALIDATE = 3'd6;

endpackage

`default_nettype wire

>>> rtl/hsr_in_if.sv
// ----------------------------------------------------------------------------
// hsr_in_if
// Request channel: operation code, handle and search start slot.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsr_in_if
  import hsr_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [HANDLE_W-1:0]       handle;
  logic signed [START_W-1:0] start_slot;

  modport source (output valid, output mode, output handle, output start_slot,
                  input ready);
  modport sink   (input valid, input mode, input handle, input start_slot,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/hsr_out_if.sv
// ----------------------------------------------------------------------------
// hsr_out_if
// Result channel: found flag, slot index, handle and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsr_out_if
  import hsr_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [SLOT_OUT_W-1:0] slot;
  logic [HANDLE_W-1:0]   handle_out;
  logic [OCC_W-1:0]      occupancy;

  modport source (output valid, output found, output slot, output handle_out,
                  output occupancy, input ready);
  modport sink   (input valid, input found, input slot, input handle_out,
                  input occupancy, output ready);
endinterface

`default_nettype wire

>>> rtl/hsr_table.sv
// ----------------------------------------------------------------------------
// hsr_table
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hsr_table #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/handle_slot_registry_unit.sv
// ----------------------------------------------------------------------------
// handle_slot_registry_unit
// Table of nonzero handles kept in slots; register, remove, find, circular
// next/prev search and occupancy count.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one operation (mode, handle, start_slot); a transfer takes
//          place when valid and ready are both high.
//   out_ch returns exactly one result per operation, in order.
//   Each operation walks the slot table through the single read port of the
//   table memory, one slot per cycle. A full walk issues SLOTS reads, then
//   takes the last read data, writes back and retires, and passes through
//   idle before it takes the next item. A walk stops at the first hit. Count,
//   unused modes and operations on handle zero that need no walk go from idle
//   straight to the retire step.
//   After reset the table is swept to empty, one slot per cycle, through all
//   SLOTS slots; in_ch.ready stays low until the sweep is done.
//   The result sits in an output register. A new operation is taken while
//   it waits; if the receiver still stalls when that operation finishes,
//   the block holds in its retire step until out_ch.ready frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_slot_registry_unit
  import hsr_pkg::*;
#(
  parameter int SLOTS       = 256,
  parameter int HANDLE_BITS = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hsr_in_if.sink    in_ch,
  hsr_out_if.source out_ch
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int HB     = HANDLE_BITS;

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  FULL_READS = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0]  PART_READS = CNT_W'(SLOTS - 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // control state
  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  issue_left_r, issue_left_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              out_valid_r, out_valid_nxt;

  // operation context and working results
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [HB-1:0]         h_r, h_nxt;
  logic [SLOT_W-1:0]     addr_r, addr_nxt;
  logic                  down_r, down_nxt;
  logic                  rd_last_r, rd_last_nxt;
  logic [SLOT_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic                  have_empty_r, have_empty_nxt;
  logic [SLOT_W-1:0]     empty_slot_r, empty_slot_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [SLOT_OUT_W-1:0] res_slot_r, res_slot_nxt;
  logic [HANDLE_W-1:0]   res_hout_r, res_hout_nxt;
  logic                  wr_pend_r, wr_pend_nxt;
  logic [SLOT_W-1:0]     wr_addr_r, wr_addr_nxt;
  logic [HB-1:0]         wr_data_r, wr_data_nxt;
  logic                  inc_r, inc_nxt;
  logic                  dec_r, dec_nxt;

  // output register
  logic                  out_found_r, out_found_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [HANDLE_W-1:0]   out_hout_r, out_hout_nxt;
  logic [OCC_W-1:0]      out_occ_r, out_occ_nxt;

  // table ports
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [HB-1:0]     mem_wd;
  logic              mem_re;
  logic [HB-1:0]     mem_q;

  // width adapters
  logic [HB+HANDLE_W-1:0]     in_h_x;
  logic [HB-1:0]              in_h;
  logic [SLOT_W+7:0]          start_x;
  logic [SLOT_W-1:0]          start_idx;
  logic                       start_full;
  logic [SLOT_W+SLOT_OUT_W-1:0] rd_slot_x;
  logic [SLOT_W+SLOT_OUT_W-1:0] empty_slot_x;
  logic [HB+HANDLE_W-1:0]     q_hout_x;
  logic [CNT_W+OCC_W-1:0]     occ_x;
  logic                       in_xfer;
  logic                       out_free;
  logic                       retire;

  assign in_h_x       = {{HB{1'b0}}, in_ch.handle};
  assign in_h         = in_h_x[HB-1:0];
  assign start_x      = {{SLOT_W{1'b0}}, in_ch.start_slot[7:0]};
  assign start_idx    = start_x[SLOT_W-1:0];
  assign start_full   = in_ch.start_slot[8] ||
                        ({24'd0, in_ch.start_slot[7:0]} >= 32'(SLOTS));
  assign rd_slot_x    = {{SLOT_OUT_W{1'b0}}, rd_addr_r};
  assign empty_slot_x = {{SLOT_OUT_W{1'b0}}, empty_slot_r};
  assign q_hout_x     = {{HANDLE_W{1'b0}}, mem_q};

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && (state_r == ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign retire      = (state_r == ST_FINISH) && out_free;

  hsr_table #(
    .DEPTH (SLOTS),
    .WIDTH (HB)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (addr_r),
    .rd_data (mem_q)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr_r;
    mem_wd = wr_data_r;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else if (retire && wr_pend_r) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cnt_nxt        = cnt_r;
    issue_left_nxt = issue_left_r;
    rd_vld_nxt     = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    mode_nxt       = mode_r;
    h_nxt          = h_r;
    addr_nxt       = addr_r;
    down_nxt       = down_r;
    rd_last_nxt    = rd_last_r;
    rd_addr_nxt    = rd_addr_r;
    have_empty_nxt = have_empty_r;
    empty_slot_nxt = empty_slot_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    res_hout_nxt   = res_hout_r;
    wr_pend_nxt    = wr_pend_r;
    wr_addr_nxt    = wr_addr_r;
    wr_data_nxt    = wr_data_r;
    inc_nxt        = inc_r;
    dec_nxt        = dec_r;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    out_hout_nxt   = out_hout_r;
    out_occ_nxt    = out_occ_r;
    mem_re         = 1'b0;
    occ_x          = '0;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + SLOT_W'(1);
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt       = in_ch.mode;
          h_nxt          = in_h;
          down_nxt       = (in_ch.mode == MODE_PREV);
          have_empty_nxt = 1'b0;
          res_found_nxt  = 1'b0;
          res_slot_nxt   = '0;
          res_hout_nxt   = '0;
          wr_pend_nxt    = 1'b0;
          inc_nxt        = 1'b0;
          dec_nxt        = 1'b0;
          addr_nxt       = '0;
          issue_left_nxt = FULL_READS;
          state_nxt      = ST_FINISH;
          case (in_ch.mode)
            MODE_REGISTER, MODE_REMOVE, MODE_INVALIDATE: begin
              if (in_h != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            MODE_FIND: begin
              state_nxt = ST_SCAN;
            end
            MODE_NEXT, MODE_PREV: begin
              state_nxt    = ST_SCAN;
              res_slot_nxt = in_ch.start_slot[7:0];
              if (start_full) begin
                addr_nxt = (in_ch.mode == MODE_PREV) ? LAST_SLOT : '0;
              end else begin
                issue_left_nxt = PART_READS;
                if (in_ch.mode == MODE_PREV) begin
                  addr_nxt = (start_idx == '0) ? LAST_SLOT : start_idx - SLOT_W'(1);
                end else begin
                  addr_nxt = (start_idx == LAST_SLOT) ? '0 : start_idx + SLOT_W'(1);
                end
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue one read a cycle while reads remain
        if (issue_left_r != '0) begin
          mem_re         = 1'b1;
          rd_vld_nxt     = 1'b1;
          rd_last_nxt    = (issue_left_r == CNT_W'(1));
          rd_addr_nxt    = addr_r;
          issue_left_nxt = issue_left_r - CNT_W'(1);
          if (down_r) begin
            addr_nxt = (addr_r == '0) ? LAST_SLOT : addr_r - SLOT_W'(1);
          end else begin
            addr_nxt = (addr_r == LAST_SLOT) ? '0 : addr_r + SLOT_W'(1);
          end
        end
        // check the slot read in the previous cycle
        if (rd_vld_r) begin
          if (mode_r inside {MODE_NEXT, MODE_PREV}) begin
            if (mem_q != '0) begin
              res_found_nxt = 1'b1;
              res_slot_nxt  = rd_slot_x[SLOT_OUT_W-1:0];
              res_hout_nxt  = q_hout_x[HANDLE_W-1:0];
              state_nxt     = ST_FINISH;
            end else if (rd_last_r) begin
              state_nxt = ST_FINISH;
            end
          end else if (mem_q == h_r) begin
            res_found_nxt = 1'b1;
            res_slot_nxt  = rd_slot_x[SLOT_OUT_W-1:0];
            state_nxt     = ST_FINISH;
            if (mode_r inside {MODE_REMOVE, MODE_INVALIDATE}) begin
              wr_pend_nxt = 1'b1;
              wr_addr_nxt = rd_addr_r;
              wr_data_nxt = '0;
              dec_nxt     = 1'b1;
            end
          end else begin
            if (mode_r == MODE_REGISTER && mem_q == '0 && !have_empty_r) begin
              have_empty_nxt = 1'b1;
              empty_slot_nxt = rd_addr_r;
            end
            if (rd_last_r) begin
              state_nxt = ST_FINISH;
              if (mode_r == MODE_REGISTER) begin
                // take the lowest empty slot, this one included
                if (have_empty_r || mem_q == '0) begin
                  res_found_nxt = 1'b1;
                  wr_pend_nxt   = 1'b1;
                  wr_data_nxt   = h_r;
                  inc_nxt       = 1'b1;
                  if (have_empty_r) begin
                    wr_addr_nxt  = empty_slot_r;
                    res_slot_nxt = empty_slot_x[SLOT_OUT_W-1:0];
                  end else begin
                    wr_addr_nxt  = rd_addr_r;
                    res_slot_nxt = rd_slot_x[SLOT_OUT_W-1:0];
                  end
                end
              end
            end
          end
        end
      end

      ST_FINISH: begin
        // hold until the output register is free, then write back and retire
        if (out_free) begin
          if (inc_r) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if (dec_r) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          occ_x         = {{OCC_W{1'b0}}, cnt_nxt};
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_slot_nxt  = res_slot_r;
          out_hout_nxt  = res_hout_r;
          out_occ_nxt   = occ_x[OCC_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      cnt_r        <= '0;
      issue_left_r <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      cnt_r        <= cnt_nxt;
      issue_left_r <= issue_left_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    h_r          <= h_nxt;
    addr_r       <= addr_nxt;
    down_r       <= down_nxt;
    rd_last_r    <= rd_last_nxt;
    rd_addr_r    <= rd_addr_nxt;
    have_empty_r <= have_empty_nxt;
    empty_slot_r <= empty_slot_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    res_hout_r   <= res_hout_nxt;
    wr_pend_r    <= wr_pend_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_data_r    <= wr_data_nxt;
    inc_r        <= inc_nxt;
    dec_r        <= dec_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hout_r   <= out_hout_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.handle_out = out_hout_r;
  assign out_ch.occupancy  = out_occ_r;

endmodule

`default_nettype wire

>>> rtl/hsr_checker.sv
// ----------------------------------------------------------------------------
// hsr_checker
// Port-level checks for the handle slot registry, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsr_checker
  import hsr_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_found,
  input wire logic [SLOT_OUT_W-1:0] out_slot,
  input wire logic [HANDLE_W-1:0]   out_handle_out,
  input wire logic [OCC_W-1:0]      out_occupancy
);

  // the table sweep after reset blocks requests and no result is pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("hsr: request taken or result shown right after reset");

  a_hout_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_handle_out != '0 |-> out_found)
    else $error("hsr: handle returned without a found slot");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({23'd0, out_occupancy} <= 32'(SLOTS)))
    else $error("hsr: occupancy above slot count");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("hsr: result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_found) && $stable(out_slot) &&
      $stable(out_handle_out) && $stable(out_occupancy))
    else $error("hsr: result changed while stalled");

endmodule

bind handle_slot_registry_unit hsr_checker #(
  .SLOTS (SLOTS)
) u_hsr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_found      (out_ch.found),
  .out_slot       (out_ch.slot),
  .out_handle_out (out_ch.handle_out),
  .out_occupancy  (out_ch.occupancy)
);

`default_nettype wire

>>> tb/handle_slot_registry_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handle_slot_registry_unit_tb
// Drives register, remove, find, next, prev, count and invalidate requests
// into the handle slot registry. A shadow copy of the slot table predicts
// every reply, and each reply is compared field by field, in order.
// ----------------------------------------------------------------------------

module handle_slot_registry_unit_tb;
  import hsr_pkg::*;

  localparam int SLOTS = 256;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic                  found;
    logic [SLOT_OUT_W-1:0] slot;
    logic [HANDLE_W-1:0]   handle_out;
    logic [OCC_W-1:0]      occupancy;
  } reply_t;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  class registry_shadow;
    logic [HANDLE_W-1:0] entry [SLOTS];
    int                  held;
    reply_t              pending_replies [$];
    int                  failures;

    function new();
      foreach (entry[i]) entry[i] = '0;
      held     = 0;
      failures = 0;
    endfunction

    function int lowest_slot_of(logic [HANDLE_W-1:0] h);
      for (int i = 0; i < SLOTS; i++)
        if (entry[i] == h) return i;
      return -1;
    endfunction

    // Pick an occupied slot's handle, starting from a random slot.
    function logic [HANDLE_W-1:0] any_held();
      int base;
      base = $urandom_range(SLOTS - 1);
      for (int k = 0; k < SLOTS; k++)
        if (entry[(base + k) % SLOTS] != '0) return entry[(base + k) % SLOTS];
      return '0;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle,
                               logic signed [START_W-1:0] start);
      reply_t r;
      int     idx;
      int     cand;
      int     s;
      bit     whole;
      r = '0;
      s = start;
      case (mode)
        MODE_REGISTER: begin
          if (handle != '0) begin
            idx = lowest_slot_of(handle);
            if (idx < 0) begin
              idx = lowest_slot_of('0);
              if (idx >= 0) begin
                entry[idx] = handle;
                held++;
              end
            end
            if (idx >= 0) begin
              r.found = 1'b1;
              r.slot  = idx[SLOT_OUT_W-1:0];
            end
          end
        end
        MODE_REMOVE, MODE_INVALIDATE: begin
          if (handle != '0) begin
            idx = lowest_slot_of(handle);
            if (idx >= 0) begin
              entry[idx] = '0;
              held--;
              r.found = 1'b1;
              r.slot  = idx[SLOT_OUT_W-1:0];
            end
          end
        end
        MODE_FIND: begin
          idx = lowest_slot_of(handle);
          if (idx >= 0) begin
            r.found = 1'b1;
            r.slot  = idx[SLOT_OUT_W-1:0];
          end
        end
        MODE_NEXT, MODE_PREV: begin
          r.slot = start[SLOT_OUT_W-1:0];
          // A start outside the table excludes no slot.
          whole = (s < 0) || (s >= SLOTS);
          for (int k = 1; k <= SLOTS; k++) begin
            if (whole) begin
              cand = (mode == MODE_NEXT) ? k - 1 : SLOTS - k;
            end else begin
              if (k == SLOTS) break;
              cand = (mode == MODE_NEXT) ? (s + k) % SLOTS : (s - k + SLOTS) % SLOTS;
            end
            if (entry[cand] != '0) begin
              r.found      = 1'b1;
              r.slot       = cand[SLOT_OUT_W-1:0];
              r.handle_out = entry[cand];
              break;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = held[OCC_W-1:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply transfer with no request pending");
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        failures++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
        failures++;
      end
      if (got.handle_out !== want.handle_out) begin
        $error("handle_out: expected %h, actual %h", want.handle_out, got.handle_out);
        failures++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
        failures++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hsr_in_if  in_ch ();
  hsr_out_if out_ch ();

  handle_slot_registry_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  registry_shadow shadow;
  int             sender_idle_pct;
  int             receiver_stall_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      shadow.check_reply({out_ch.found, out_ch.slot, out_ch.handle_out, out_ch.occupancy});
  end

  // Keep valid high between back-to-back requests; drop it only while idle.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
                              input logic signed [START_W-1:0] start);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.mode       = mode;
    in_ch.handle     = handle;
    in_ch.start_slot = start;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_request(mode, handle, start);
  endtask

  function automatic logic [MODE_W-1:0] pick_mode(mix_t mix);
    int                w [8];
    logic [MODE_W-1:0] order [8];
    int                r;
    int                acc;
    order = '{MODE_REGISTER, MODE_REMOVE, MODE_FIND, MODE_NEXT,
              MODE_PREV, MODE_COUNT, MODE_INVALIDATE, MODE_UNUSED};
    case (mix)
      MIX_FILL:     w = '{88, 2, 3, 2, 2, 1, 1, 1};
      MIX_BALANCED: w = '{30, 15, 15, 12, 12, 5, 8, 3};
      default:      w = '{5, 45, 8, 10, 10, 2, 18, 2};
    endcase
    r   = $urandom_range(99);
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      acc += w[i];
      if (r < acc) return order[i];
    end
    return MODE_COUNT;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle(logic [MODE_W-1:0] mode, mix_t mix);
    int r;
    int fresh_pct;
    if (mode == MODE_REGISTER) fresh_pct = (mix == MIX_FILL) ? 95 : 70;
    else                       fresh_pct = 20;
    r = $urandom_range(99);
    if (r < fresh_pct) return $urandom;
    if (r < fresh_pct + 12) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return shadow.any_held();
  endfunction

  function automatic logic [START_W-1:0] pick_start();
    case ($urandom_range(9))
      0:       return 9'h1FF;
      1:       return 9'h100;
      2:       return 9'h000;
      3:       return 9'h0FF;
      default: return START_W'($urandom_range(511));
    endcase
  endfunction

  task automatic run_random(input int count, input int idle_pct, input int stall_pct,
                            input mix_t mix);
    logic [MODE_W-1:0] mode;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      mode = pick_mode(mix);
      send_request(mode, pick_handle(mode, mix), pick_start());
    end
  endtask

  initial begin
    shadow             = new();
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_COUNT;
    in_ch.handle       = '0;
    in_ch.start_slot   = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Empty table first, then a few handles around the field extremes.
    send_request(MODE_COUNT,      32'h0000_0000, 9'sd0);
    send_request(MODE_NEXT,       32'h0000_0000, -9'sd1);
    send_request(MODE_PREV,       32'h0000_0000, 9'sd10);
    send_request(MODE_REGISTER,   32'h0000_0000, 9'sd0);
    send_request(MODE_FIND,       32'h0000_0000, 9'sd0);
    send_request(MODE_REGISTER,   32'hFFFF_FFFF, 9'sd0);
    send_request(MODE_REGISTER,   32'h0000_0001, 9'sd0);
    send_request(MODE_REGISTER,   32'h8000_0000, 9'sd0);
    send_request(MODE_REGISTER,   32'hFFFF_FFFF, 9'sd255);
    send_request(MODE_FIND,       32'h0000_0001, 9'sd0);
    send_request(MODE_FIND,       32'h1234_5678, 9'sd0);
    send_request(MODE_REMOVE,     32'h0000_0001, 9'sd0);
    send_request(MODE_REMOVE,     32'h0000_0001, 9'sd0);
    send_request(MODE_REMOVE,     32'h0000_0000, 9'sd0);
    send_request(MODE_INVALIDATE, 32'h0000_0000, 9'sd0);
    send_request(MODE_INVALIDATE, 32'hFFFF_FFFF, 9'sd0);
    send_request(MODE_FIND,       32'h0000_0000, 9'sd0);
    send_request(MODE_NEXT,       32'h0000_0000, 9'sd2);
    send_request(MODE_PREV,       32'h0000_0000, -9'sd256);
    send_request(MODE_NEXT,       32'h0000_0000, 9'sd255);
    send_request(MODE_PREV,       32'h0000_0000, 9'sd0);
    send_request(MODE_REGISTER,   32'h0000_0002, 9'sd0);
    send_request(MODE_UNUSED,     32'hA5A5_A5A5, -9'sd1);
    send_request(MODE_COUNT,      32'hFFFF_FFFF, 9'sd255);

    run_random(350, 0, 0, MIX_FILL);
    run_random(250, 88, 0, MIX_DRAIN);
    run_random(200, 0, 88, MIX_BALANCED);
    run_random(250, 26, 26, MIX_DRAIN);

    @(negedge clk);
    in_ch.valid        = 1'b0;
    receiver_stall_pct = 0;
    while (shadow.pending_replies.size() != 0) @(posedge clk);
    repeat (2 * (SLOTS + 3)) @(posedge clk);

    if (shadow.failures == 0 && shadow.pending_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
